[src/ppt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and fixed constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int BEST_W     = 51;
  localparam int WRAP_W     = 64;
  localparam int LOC_W      = 2;
  localparam int NUM_OUT_W  = 50;
  localparam int DEN_OUT_W  = 25;
  localparam int OUT_W      = ((LOC_W + NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_W - LOC_W - NUM_OUT_W - DEN_OUT_W;
  localparam int MUL_MIN_W  = (BEST_W + 1) / 2;

  typedef logic [LOC_W-1:0] loc_t;

  localparam loc_t LOC_OUTSIDE  = 2'd0;
  localparam loc_t LOC_INSIDE   = 2'd1;
  localparam loc_t LOC_BOUNDARY = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE,
    ST_X1,
    ST_PLAIN_UPD,
    ST_D1A,
    ST_D1B,
    ST_D2A,
    ST_D2B,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_LATCH,
    ST_CMP0,
    ST_CMP1,
    ST_CMP2,
    ST_CMP3,
    ST_DIST_UPD,
    ST_NEXT
  } state_t;

  typedef enum logic [1:0] {
    NEAR_A,
    NEAR_B,
    NEAR_SEG
  } near_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shift;
  } mac_ctl_t;

endpackage
`default_nettype wire

[src/ppt_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_mac
// Shared signed multiply-accumulate unit: one product per cycle when enabled,
// optionally shifted up one limb, added to or subtracted from a registered sum.
// ----------------------------------------------------------------------------
module ppt_mac #(
  parameter int OPW   = 27,
  parameter int ACC_W = 78,
  parameter int SHIFT = 26
) (
  input  logic                    clk,
  input  ppt_pkg::mac_ctl_t       ctl,
  input  logic signed [OPW-1:0]   op_a,
  input  logic signed [OPW-1:0]   op_b,
  output logic signed [ACC_W-1:0] acc
);
  import ppt_pkg::*;

  logic signed [2*OPW-1:0]  prod;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  term_sh;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign prod    = op_a * op_b;
  assign term    = ACC_W'(prod);
  assign term_sh = ctl.shift ? (term <<< SHIFT) : term;
  assign acc_nxt = (ctl.clr ? '0 : acc_r) + (ctl.sub ? -term_sh : term_sh);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

[src/point_polygon_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_polygon_test
// Crossing-number point-in-polygon test over a stream of vertices, with an
// optional exact minimum squared distance reported as numerator/denominator.
// ----------------------------------------------------------------------------
// Vertices stream in one item at a time, each carrying the query point; the
// item with tlast closes the polygon and yields one result (0 outside,
// 1 inside, 2 on boundary, plus the distance pair in distance mode). All
// products go through one multiply-accumulate unit under a sequencer, so an
// item is taken only when the previous one is done. The first vertex of a
// polygon is only stored; every other vertex is stored and then runs its
// edge. In plain mode an edge is a cross product and a parity update, or
// just the ray test when that skips it; in distance mode it is the cross
// product, two dot products, the squared distance and the fraction compare,
// built from four limb products. The last vertex adds the closing edge.
// Once the boundary is found, further edges are passed over. A result
// register lets the next item in while the result still waits.
// ----------------------------------------------------------------------------
module point_polygon_test #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y, vertex_x, vertex_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // location, dist_numerator, dist_denominator
  output logic [ppt_pkg::OUT_W-1:0]              out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_data
);
  import ppt_pkg::*;

  localparam int C        = COORD_BITS;
  localparam int DIFF_W   = C + 1;
  localparam int CROSS_W  = 2 * C + 2;
  localparam int CMAG_W   = 2 * C + 1;
  localparam int DEN_W    = 2 * C + 1;
  localparam int SQ_W     = 4 * C + 2;
  localparam int NUM_CAP  = (SQ_W > WRAP_W) ? WRAP_W : SQ_W;
  localparam int NUM_W    = (NUM_CAP > BEST_W) ? NUM_CAP : BEST_W;
  localparam int MUL_W    = (CMAG_W > MUL_MIN_W) ? CMAG_W : MUL_MIN_W;
  localparam int OPW      = MUL_W + 1;
  localparam int ACC_W    = NUM_W + DEN_W + 2;
  localparam int HI_W     = NUM_W - MUL_W;

  // control state
  state_t                   state_r, state_nxt;
  logic                     awaiting_r, awaiting_nxt;
  logic                     onb_r, onb_nxt;
  logic                     parity_r, parity_nxt;
  logic                     md_r, md_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]         best_num_r, best_num_nxt;
  logic [DEN_W-1:0]         best_den_r, best_den_nxt;

  // payload
  logic signed [C-1:0]      px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic signed [C-1:0]      first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                     last_r, dm_r, closing_r, dot1_le0_r;
  near_t                    kind_r;
  logic signed [CROSS_W-1:0] cross_r;
  logic [NUM_W-1:0]         num_r;
  logic [DEN_W-1:0]         den_r;
  loc_t                     out_loc_r;
  logic [NUM_OUT_W-1:0]     out_num_r;
  logic [DEN_OUT_W-1:0]     out_den_r;

  logic signed [C-1:0]      in_px, in_py, in_vx, in_vy;
  logic                     in_fire;
  logic                     out_load;
  logic                     closing_load;

  logic signed [DIFF_W-1:0] dx, dy, dx1, dy1, dx2, dy2;
  logic signed [OPW-1:0]    dx_e, dy_e, dx1_e, dy1_e, dx2_e, dy2_e;
  logic signed [CROSS_W-1:0] cross_abs;
  logic signed [OPW-1:0]    cmag_e, num_hi_e, num_lo_e, bnum_hi_e, bnum_lo_e;
  logic signed [OPW-1:0]    den_e, bden_e;
  logic [DEN_W+DEN_OUT_W-1:0] best_den_wide;

  logic                     skip, plain_bnd;
  logic                     acc_neg, acc_zero, acc_le0;
  logic                     cross_pos, cross_neg;
  logic                     toggle_plain, toggle_dist;
  near_t                    kind_now;

  mac_ctl_t                 mac_ctl;
  logic signed [OPW-1:0]    op_a, op_b;
  logic signed [ACC_W-1:0]  acc;

  assign in_px = in_tdata[C-1:0];
  assign in_py = in_tdata[2*C-1:C];
  assign in_vx = in_tdata[3*C-1:2*C];
  assign in_vy = in_tdata[4*C-1:3*C];

  assign in_tready    = (state_r == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign in_fire      = in_tvalid && in_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{OUT_PAD_W{1'b0}}, out_den_r, out_num_r, out_loc_r};

  assign out_load     = (state_r == ST_NEXT) && last_r && closing_r &&
                        (!out_valid_r || out_tready);
  assign closing_load = (state_r == ST_NEXT) && last_r && !closing_r;

  // edge differences
  assign dx  = DIFF_W'(bx_r) - DIFF_W'(ax_r);
  assign dy  = DIFF_W'(by_r) - DIFF_W'(ay_r);
  assign dx1 = DIFF_W'(px_r) - DIFF_W'(ax_r);
  assign dy1 = DIFF_W'(py_r) - DIFF_W'(ay_r);
  assign dx2 = DIFF_W'(px_r) - DIFF_W'(bx_r);
  assign dy2 = DIFF_W'(py_r) - DIFF_W'(by_r);

  assign dx_e  = OPW'(dx);
  assign dy_e  = OPW'(dy);
  assign dx1_e = OPW'(dx1);
  assign dy1_e = OPW'(dy1);
  assign dx2_e = OPW'(dx2);
  assign dy2_e = OPW'(dy2);

  assign cross_abs = cross_r[CROSS_W-1] ? -cross_r : cross_r;
  assign cmag_e    = {{(OPW-CMAG_W){1'b0}}, cross_abs[CMAG_W-1:0]};
  assign num_hi_e  = {{(OPW-HI_W){1'b0}}, num_r[NUM_W-1:MUL_W]};
  assign num_lo_e  = {1'b0, num_r[MUL_W-1:0]};
  assign bnum_hi_e = {{(OPW-HI_W){1'b0}}, best_num_r[NUM_W-1:MUL_W]};
  assign bnum_lo_e = {1'b0, best_num_r[MUL_W-1:0]};
  assign den_e     = {{(OPW-DEN_W){1'b0}}, den_r};
  assign bden_e    = {{(OPW-DEN_W){1'b0}}, best_den_r};
  assign best_den_wide = {{DEN_OUT_W{1'b0}}, best_den_r};

  assign skip = (ay_r <= py_r && by_r <= py_r) || (ay_r > py_r && by_r > py_r) ||
                (ax_r < px_r && bx_r < px_r);
  assign plain_bnd = (py_r == by_r) &&
                     ((px_r == bx_r) ||
                      ((py_r == ay_r) &&
                       ((ax_r <= px_r && px_r <= bx_r) ||
                        (bx_r <= px_r && px_r <= ax_r))));

  assign acc_neg   = acc[ACC_W-1];
  assign acc_zero  = (acc == '0);
  assign acc_le0   = acc_neg || acc_zero;
  assign cross_neg = cross_r[CROSS_W-1];
  assign cross_pos = !cross_neg && (cross_r != '0);

  assign toggle_plain = dy[DIFF_W-1] ? acc_neg : (!acc_neg && !acc_zero);
  assign toggle_dist  = dy[DIFF_W-1] ? cross_neg : cross_pos;

  assign kind_now = dot1_le0_r ? NEAR_A : (acc_neg ? NEAR_SEG : NEAR_B);

  ppt_mac #(
    .OPW   (OPW),
    .ACC_W (ACC_W),
    .SHIFT (MUL_W)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // operand selection for the shared unit
  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    unique case (state_r)
      ST_EDGE: begin
        mac_ctl.en = 1'b1; mac_ctl.clr = 1'b1;
        op_a = dy1_e; op_b = dx_e;
      end
      ST_X1: begin
        mac_ctl.en = 1'b1; mac_ctl.sub = 1'b1;
        op_a = dx1_e; op_b = dy_e;
      end
      ST_D1A: begin
        mac_ctl.en = 1'b1; mac_ctl.clr = 1'b1;
        op_a = dx1_e; op_b = dx_e;
      end
      ST_D1B: begin
        mac_ctl.en = 1'b1;
        op_a = dy1_e; op_b = dy_e;
      end
      ST_D2A: begin
        mac_ctl.en = 1'b1; mac_ctl.clr = 1'b1;
        op_a = dx2_e; op_b = dx_e;
      end
      ST_D2B: begin
        mac_ctl.en = 1'b1;
        op_a = dy2_e; op_b = dy_e;
      end
      ST_SQ0: begin
        mac_ctl.en = 1'b1; mac_ctl.clr = 1'b1;
        unique case (kind_now)
          NEAR_A:  begin op_a = dx1_e;  op_b = dx1_e;  end
          NEAR_B:  begin op_a = dx2_e;  op_b = dx2_e;  end
          default: begin op_a = cmag_e; op_b = cmag_e; end
        endcase
      end
      ST_SQ1: begin
        mac_ctl.en = 1'b1;
        unique case (kind_r)
          NEAR_A:  begin op_a = dy1_e; op_b = dy1_e; end
          NEAR_B:  begin op_a = dy2_e; op_b = dy2_e; end
          default: begin mac_ctl.clr = 1'b1; op_a = dx_e; op_b = dx_e; end
        endcase
      end
      ST_SQ2: begin
        mac_ctl.en = 1'b1;
        op_a = dy_e; op_b = dy_e;
      end
      ST_CMP0: begin
        mac_ctl.en = 1'b1; mac_ctl.clr = 1'b1; mac_ctl.shift = 1'b1;
        op_a = num_hi_e; op_b = bden_e;
      end
      ST_CMP1: begin
        mac_ctl.en = 1'b1;
        op_a = num_lo_e; op_b = bden_e;
      end
      ST_CMP2: begin
        mac_ctl.en = 1'b1; mac_ctl.sub = 1'b1; mac_ctl.shift = 1'b1;
        op_a = bnum_hi_e; op_b = den_e;
      end
      ST_CMP3: begin
        mac_ctl.en = 1'b1; mac_ctl.sub = 1'b1;
        op_a = bnum_lo_e; op_b = den_e;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    onb_nxt       = onb_r;
    parity_nxt    = parity_r;
    best_num_nxt  = best_num_r;
    best_den_nxt  = best_den_r;
    md_nxt        = cfg_valid ? cfg_data : md_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          awaiting_nxt = 1'b0;
          state_nxt    = (awaiting_r && !in_tlast) ? ST_IDLE : ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (onb_r) begin
          state_nxt = ST_NEXT;
        end else if (!dm_r && skip) begin
          if (plain_bnd) begin
            onb_nxt = 1'b1;
          end
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_X1;
        end
      end
      ST_X1:        state_nxt = dm_r ? ST_D1A : ST_PLAIN_UPD;
      ST_PLAIN_UPD: begin
        if (acc_zero) begin
          onb_nxt = 1'b1;
        end else if (toggle_plain) begin
          parity_nxt = !parity_r;
        end
        state_nxt = ST_NEXT;
      end
      ST_D1A:       state_nxt = ST_D1B;
      ST_D1B:       state_nxt = ST_D2A;
      ST_D2A:       state_nxt = ST_D2B;
      ST_D2B:       state_nxt = ST_SQ0;
      ST_SQ0:       state_nxt = ST_SQ1;
      ST_SQ1:       state_nxt = (kind_r == NEAR_SEG) ? ST_SQ2 : ST_LATCH;
      ST_SQ2:       state_nxt = ST_LATCH;
      ST_LATCH:     state_nxt = ST_CMP0;
      ST_CMP0:      state_nxt = ST_CMP1;
      ST_CMP1:      state_nxt = ST_CMP2;
      ST_CMP2:      state_nxt = ST_CMP3;
      ST_CMP3:      state_nxt = ST_DIST_UPD;
      ST_DIST_UPD: begin
        if (acc_neg) begin
          best_num_nxt = num_r;
          best_den_nxt = den_r;
        end
        if (acc_neg && num_r == '0) begin
          onb_nxt = 1'b1;
        end else if (!skip && toggle_dist) begin
          parity_nxt = !parity_r;
        end
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (closing_load) begin
          state_nxt = ST_EDGE;
        end else if (last_r) begin
          if (out_load) begin
            out_valid_nxt = 1'b1;
            awaiting_nxt  = 1'b1;
            onb_nxt       = 1'b0;
            parity_nxt    = 1'b0;
            best_num_nxt  = NUM_W'({BEST_W{1'b1}});
            best_den_nxt  = DEN_W'(1);
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b1;
      onb_r       <= 1'b0;
      parity_r    <= 1'b0;
      md_r        <= 1'b0;
      out_valid_r <= 1'b0;
      best_num_r  <= NUM_W'({BEST_W{1'b1}});
      best_den_r  <= DEN_W'(1);
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      onb_r       <= onb_nxt;
      parity_r    <= parity_nxt;
      md_r        <= md_nxt;
      out_valid_r <= out_valid_nxt;
      best_num_r  <= best_num_nxt;
      best_den_r  <= best_den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r      <= in_px;
      py_r      <= in_py;
      ax_r      <= awaiting_r ? in_vx : prev_x_r;
      ay_r      <= awaiting_r ? in_vy : prev_y_r;
      bx_r      <= in_vx;
      by_r      <= in_vy;
      prev_x_r  <= in_vx;
      prev_y_r  <= in_vy;
      last_r    <= in_tlast;
      dm_r      <= md_r;
      closing_r <= awaiting_r;
      if (awaiting_r) begin
        first_x_r <= in_vx;
        first_y_r <= in_vy;
      end
    end
    if (closing_load) begin
      ax_r      <= bx_r;
      ay_r      <= by_r;
      bx_r      <= first_x_r;
      by_r      <= first_y_r;
      closing_r <= 1'b1;
    end
    if (state_r == ST_D1A) begin
      cross_r <= acc[CROSS_W-1:0];
    end
    if (state_r == ST_D2A) begin
      dot1_le0_r <= acc_le0;
    end
    if (state_r == ST_SQ0) begin
      kind_r <= kind_now;
    end
    if (state_r == ST_SQ1 && kind_r == NEAR_SEG) begin
      num_r <= acc[NUM_W-1:0];
    end
    if (state_r == ST_LATCH) begin
      if (kind_r == NEAR_SEG) begin
        den_r <= acc[DEN_W-1:0];
      end else begin
        num_r <= acc[NUM_W-1:0];
        den_r <= DEN_W'(1);
      end
    end
    if (out_load) begin
      out_loc_r <= onb_r ? LOC_BOUNDARY : (parity_r ? LOC_INSIDE : LOC_OUTSIDE);
      out_num_r <= dm_r ? best_num_r[NUM_OUT_W-1:0] : '0;
      out_den_r <= dm_r ? best_den_wide[DEN_OUT_W-1:0] : DEN_OUT_W'(1);
    end
  end

  a_fresh_polygon: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (!onb_r && !parity_r))
    else $error("polygon state not clear while waiting for first vertex");

  a_boundary_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDGE && onb_r) |=> (state_r == ST_NEXT))
    else $error("edge processed after boundary was found");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_den_r != '0)
    else $error("best distance denominator is zero");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && awaiting_r && state_r == ST_IDLE))
    else $error("result load did not restart the polygon");

endmodule
`default_nettype wire

[tb/point_polygon_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_polygon_test_tb
// Self-checking bench for the streaming point-in-polygon test. Polygons go
// in as vertex items, with directed corner cases first and then random
// shapes in both modes. Sender bursts and receiver stalls vary the timing.
// An in-bench crossing-number and distance tracker predicts each verdict,
// and the verdicts are compared field by field as they come out.
// ----------------------------------------------------------------------------
module point_polygon_test_tb;
  import ppt_pkg::*;

  localparam int CW           = 12;
  localparam int IN_W         = ((4 * CW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 48;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    loc_t                   location;
    logic [NUM_OUT_W-1:0]   numer;
    logic [DEN_OUT_W-1:0]   denom;
  } verdict_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            in_tlast   = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic            cfg_data   = 1'b0;

  point_polygon_test #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // tracker state, mirrors the polygon accumulation of the block
  bit          dist_mode;
  bit          fresh_shape;
  longint      first_x, first_y, prev_x, prev_y;
  bit          parity;
  bit          on_edge;
  logic [63:0] best_num, best_den;

  verdict_t expected_verdicts[$];

  int fault_count;
  int cycle_count;
  int vertices_sent;
  int burst_left;
  int loc_tally[3];
  int dist_polygons;

  coord_t shape_x[$];
  coord_t shape_y[$];

  // ---------------------------------------------------------------- tracker
  function automatic logic [63:0] square_of(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return 64'(m) * 64'(m);
  endfunction

  function automatic bit ratio_less(logic [63:0] n1, logic [63:0] d1,
                                    logic [63:0] n2, logic [63:0] d2);
    logic [127:0] lhs, rhs;
    lhs = 128'(n1) * 128'(d2);
    rhs = 128'(n2) * 128'(d1);
    return lhs < rhs;
  endfunction

  function automatic void clear_shape();
    fresh_shape = 1'b1;
    first_x = 0;
    first_y = 0;
    prev_x = 0;
    prev_y = 0;
    parity = 1'b0;
    on_edge = 1'b0;
    best_num = (64'd1 << 51) - 1;
    best_den = 64'd1;
  endfunction

  function automatic void trace_edge(longint ax, longint ay, longint bx, longint by,
                                     longint px, longint py, bit dm);
    longint dx, dy, dx1, dy1, dx2, dy2, c;
    bit skip, toggle;
    logic [63:0] num, den;
    if (on_edge) return;
    dx = bx - ax;
    dy = by - ay;
    dx1 = px - ax;
    dy1 = py - ay;
    dx2 = px - bx;
    dy2 = py - by;
    skip = (ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px);
    c = dy1 * dx - dx1 * dy;
    if (dm) begin
      den = 64'd1;
      if (dx1 * dx + dy1 * dy <= 0) begin
        num = square_of(dx1) + square_of(dy1);
      end else if (dx2 * dx + dy2 * dy >= 0) begin
        num = square_of(dx2) + square_of(dy2);
      end else begin
        num = square_of(c);
        den = square_of(dx) + square_of(dy);
      end
      if (ratio_less(num, den, best_num, best_den)) begin
        best_num = num;
        best_den = den;
        if (num == 0) begin
          on_edge = 1'b1;
          return;
        end
      end
      if (skip) return;
      toggle = (dy < 0) ? (c < 0) : (c > 0);
      if (toggle) parity = ~parity;
      return;
    end
    if (skip) begin
      if (py == by && (px == bx || (py == ay &&
          ((ax <= px && px <= bx) || (bx <= px && px <= ax)))))
        on_edge = 1'b1;
      return;
    end
    if (c == 0) begin
      on_edge = 1'b1;
      return;
    end
    toggle = (by < ay) ? (c < 0) : (c > 0);
    if (toggle) parity = ~parity;
  endfunction

  function automatic void absorb_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                                        bit last);
    verdict_t v;
    if (fresh_shape) begin
      first_x = vx;
      first_y = vy;
      fresh_shape = 1'b0;
    end else begin
      trace_edge(prev_x, prev_y, vx, vy, px, py, dist_mode);
    end
    prev_x = vx;
    prev_y = vy;
    if (!last) return;
    trace_edge(vx, vy, first_x, first_y, px, py, dist_mode);
    v.location = on_edge ? LOC_BOUNDARY : (parity ? LOC_INSIDE : LOC_OUTSIDE);
    if (dist_mode) begin
      v.numer = best_num[NUM_OUT_W-1:0];
      v.denom = best_den[DEN_OUT_W-1:0];
      dist_polygons++;
    end else begin
      v.numer = '0;
      v.denom = DEN_OUT_W'(1);
    end
    expected_verdicts.push_back(v);
    clear_shape();
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy, bit last);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {vy, vx, py, px};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_vertex(px, py, vx, vy, last);
    vertices_sent++;
  endtask

  task automatic send_shape(coord_t px, coord_t py, bit roam);
    int n;
    n = shape_x.size();
    for (int i = 0; i < n; i++) begin
      if (roam && i > 0 && $urandom_range(0, 2) == 0) begin
        px = coord_t'($urandom_range(0, 4095));
        py = coord_t'($urandom_range(0, 4095));
      end
      send_vertex(px, py, shape_x[i], shape_y[i], i == n - 1);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_mode(bit use_dist);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= use_dist;
    do @(posedge clk); while (!cfg_ready);
    dist_mode = use_dist;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t pick_coord(int span);
    if (span >= 2048) return coord_t'($urandom_range(0, 4095));
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_plain_directed();
    write_mode(1'b0);
    // full-range triangle around the origin
    send_vertex(0, 0, -2048, -2048, 1'b0);
    send_vertex(0, 0, 2047, -2048, 1'b0);
    send_vertex(0, 0, 0, 2047, 1'b1);
    // point on a vertex
    send_vertex(4, 0, 0, 0, 1'b0);
    send_vertex(4, 0, 4, 0, 1'b0);
    send_vertex(4, 0, 0, 4, 1'b1);
    // point on a horizontal edge
    send_vertex(2, 0, 0, 0, 1'b0);
    send_vertex(2, 0, 4, 0, 1'b0);
    send_vertex(2, 0, 0, 4, 1'b1);
    // point on a slanted edge, zero cross product
    send_vertex(2, 2, 0, 0, 1'b0);
    send_vertex(2, 2, 4, 0, 1'b0);
    send_vertex(2, 2, 0, 4, 1'b1);
    // single vertex equal to the point
    send_vertex(5, 5, 5, 5, 1'b1);
    // query point moves between items
    send_vertex(1, 1, 0, 0, 1'b0);
    send_vertex(-7, 3, 8, 0, 1'b0);
    send_vertex(3, 2, 0, 8, 1'b1);
    // opposite corner extremes, point outside
    send_vertex(-2048, 2047, 2047, -2048, 1'b0);
    send_vertex(-2048, 2047, 2047, 2047, 1'b0);
    send_vertex(-2048, 2047, 0, -2048, 1'b1);
    settle();
  endtask

  task automatic test_distance_directed();
    write_mode(1'b1);
    send_vertex(1, 1, 0, 0, 1'b0);
    send_vertex(1, 1, 8, 0, 1'b0);
    send_vertex(1, 1, 0, 8, 1'b1);
    // single vertex at the far corner
    send_vertex(2047, -2048, -2048, 2047, 1'b1);
    settle();
  endtask

  // boundary found in plain mode, then the closing edge in distance mode
  task automatic test_mode_switch_mid_polygon();
    write_mode(1'b0);
    send_vertex(4, 0, 0, 0, 1'b0);
    send_vertex(4, 0, 4, 0, 1'b0);
    settle();
    write_mode(1'b1);
    send_vertex(4, 0, 0, 4, 1'b1);
    settle();
  endtask

  task automatic test_random_polygons(bit use_dist, int target);
    int start, n, span, pick, k;
    coord_t px, py;
    bit roam;
    write_mode(use_dist);
    start = vertices_sent;
    while (vertices_sent - start < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: span = 4;
        1: span = 40;
        2: span = 600;
        default: span = 2048;
      endcase
      shape_x.delete();
      shape_y.delete();
      for (int i = 0; i < n; i++) begin
        shape_x.push_back(pick_coord(span));
        shape_y.push_back(pick_coord(span));
      end
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, n - 1);
      if (pick < 2) begin
        px = shape_x[k];
        py = shape_y[k];
      end else if (pick == 2) begin
        px = coord_t'((int'(shape_x[k]) + int'(shape_x[(k + 1) % n])) / 2);
        py = coord_t'((int'(shape_y[k]) + int'(shape_y[(k + 1) % n])) / 2);
      end else begin
        px = pick_coord(span);
        py = pick_coord(span);
      end
      roam = ($urandom_range(0, 15) == 0);
      send_shape(px, py, roam);
    end
    settle();
  endtask

  // ---------------------------------------------------------------- receiver
  int stall_left;
  int stall_style;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_style)
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= 1'b1;
    endcase
  end

  verdict_t want;
  loc_t     got_loc;
  logic [NUM_OUT_W-1:0] got_num;
  logic [DEN_OUT_W-1:0] got_den;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_loc = out_tdata[LOC_W-1:0];
      got_num = out_tdata[LOC_W +: NUM_OUT_W];
      got_den = out_tdata[LOC_W + NUM_OUT_W +: DEN_OUT_W];
      if (expected_verdicts.size() == 0) begin
        $error("result item with no expectation pending");
        fault_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (want.location <= LOC_BOUNDARY) loc_tally[want.location]++;
        if (got_loc !== want.location) begin
          $error("location mismatch: expected %0d, got %0d", want.location, got_loc);
          fault_count++;
        end
        if (got_num !== want.numer) begin
          $error("dist_numerator mismatch: expected %0d, got %0d", want.numer, got_num);
          fault_count++;
        end
        if (got_den !== want.denom) begin
          $error("dist_denominator mismatch: expected %0d, got %0d", want.denom,
                 got_den);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    clear_shape();
    dist_mode = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_plain_directed();
    test_distance_directed();
    test_mode_switch_mid_polygon();
    test_random_polygons(1'b0, 300);
    test_random_polygons(1'b1, 350);
    test_random_polygons(1'b0, 250);
    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      fault_count++;
    end
    $display("%0d vertices sent, %0d polygons in distance mode", vertices_sent,
             dist_polygons);
    $display("verdicts: outside %0d, inside %0d, boundary %0d", loc_tally[0],
             loc_tally[1], loc_tally[2]);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/ppt_pkg.sv
src/ppt_mac.sv
src/point_polygon_test.sv
tb/point_polygon_test_tb.sv
